[hdl/u8vrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package u8vrs_pkg;

  // Output queue depth; it must hold a full open sequence plus some slack.
  localparam int DEFAULT_FIFO_DEPTH = 16;

  // Longest run of lead and continuation bytes that may be held open.
  localparam logic [2:0] PEND_DEPTH = 3'd6;

  localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
  localparam logic [31:0] SURR_LO    = 32'h0000_D800;
  localparam logic [31:0] SURR_HI    = 32'h0000_DFFF;
  localparam logic [31:0] LIM_LEN1   = 32'h0000_007F;
  localparam logic [31:0] LIM_LEN2   = 32'h0000_07FF;
  localparam logic [31:0] LIM_LEN3   = 32'h0000_FFFF;
  localparam logic [31:0] LIM_LEN4   = 32'h001F_FFFF;
  localparam logic [31:0] LIM_LEN5   = 32'h03FF_FFFF;
  localparam logic [15:0] NONCHAR_FE = 16'hFFFE;
  localparam logic [15:0] NONCHAR_FF = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DISALLOW_NC = 2'd0;
  localparam logic [1:0] CFG_REPL_BYTE   = 2'd1;
  localparam logic [1:0] CFG_REPL_EN     = 2'd2;

  localparam logic [7:0] REPL_BYTE_RESET = 8'd63;

  // One run of result words caused by one input word. The first count_a
  // words carry valid_a, the remaining word (if any) carries valid_b.
  typedef struct packed {
    logic [2:0] count;
    logic [2:0] count_a;
    logic       valid_a;
    logic       valid_b;
    logic       eos;
    logic       str_ok;
  } run_t;

  // Number of leading one bits of a lead byte, with 0xFE and 0xFF giving 7.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[5])      len = 3'd2;
    else if (!b[4]) len = 3'd3;
    else if (!b[3]) len = 3'd4;
    else if (!b[2]) len = 3'd5;
    else if (!b[1]) len = 3'd6;
    else            len = 3'd7;
    return len;
  endfunction

  // Payload bits below the length marker of a lead byte.
  function automatic logic [7:0] lead_payload(input logic [7:0] b, input logic [2:0] len);
    logic [7:0] mask;
    mask = 8'hFF >> ({1'b0, len} + 4'd1);
    return b & mask;
  endfunction

  function automatic logic [2:0] shortest_len(input logic [31:0] cp);
    logic [2:0] len;
    if (cp > LIM_LEN5)      len = 3'd6;
    else if (cp > LIM_LEN4) len = 3'd5;
    else if (cp > LIM_LEN3) len = 3'd4;
    else if (cp > LIM_LEN2) len = 3'd3;
    else if (cp > LIM_LEN1) len = 3'd2;
    else                    len = 3'd1;
    return len;
  endfunction

  function automatic logic seq_ok(input logic [31:0] cp, input logic [2:0] len,
                                  input logic disallow_nc);
    logic ok;
    ok = 1'b1;
    if (cp >= SURR_LO && cp <= SURR_HI) ok = 1'b0;
    if (cp > CP_MAX) ok = 1'b0;
    if (disallow_nc && (cp[15:0] == NONCHAR_FE || cp[15:0] == NONCHAR_FF)) ok = 1'b0;
    if (len > shortest_len(cp)) ok = 1'b0;
    return ok;
  endfunction

endpackage

`default_nettype wire

[hdl/u8vrs_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface u8vrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8vrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       string_last;
  logic       string_valid;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output string_last, output string_valid, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input string_last, input string_valid, output ready);
endinterface

`default_nettype wire

[hdl/u8vrs_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sequence tracker. Decides, for each accepted word, which held and current
// words are now released and with what validity. The bytes themselves live
// in the output queue of the top level.
module u8vrs_scan (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_en,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_string,
  input  wire logic            disallow_nc,
  output logic                 run_push,
  output u8vrs_pkg::run_t      run
);
  import u8vrs_pkg::*;

  logic [2:0]  pc_r, pc_nxt;
  logic [2:0]  el_r, el_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        seen_inv_r, seen_inv_nxt;

  logic        is_ascii, is_cont;
  logic [31:0] acc_ext;
  logic [3:0]  pc_inc;
  logic [2:0]  flush_cnt;
  logic        valid_a, valid_b, has_cur, start_new, extend, ok, any_bad;
  logic [2:0]  new_len;

  always_comb begin
    is_ascii  = !data_byte[7];
    is_cont   = (data_byte[7:6] == 2'b10);
    acc_ext   = {acc_r[25:0], data_byte[5:0]};
    pc_inc    = {1'b0, pc_r} + 4'd1;
    new_len   = lead_len(data_byte);
    ok        = seq_ok(acc_ext, pc_inc[2:0], disallow_nc);
    flush_cnt = 3'd0;
    valid_a   = 1'b0;
    valid_b   = 1'b0;
    has_cur   = 1'b0;
    start_new = 1'b0;
    extend    = 1'b0;
    if (pc_r != 3'd0 && is_cont) begin
      if (pc_inc >= {1'b0, el_r}) begin
        flush_cnt = pc_r;
        valid_a   = ok;
        valid_b   = ok;
        has_cur   = 1'b1;
      end else if (end_of_string || pc_r >= PEND_DEPTH) begin
        flush_cnt = pc_r;
        has_cur   = 1'b1;
      end else begin
        extend = 1'b1;
      end
    end else begin
      // A sequence broken by a non-continuation is released invalid and
      // the breaking byte is then treated as a fresh one.
      flush_cnt = pc_r;
      if (is_ascii) begin
        has_cur = 1'b1;
        valid_b = 1'b1;
      end else if (is_cont || end_of_string) begin
        has_cur = 1'b1;
      end else begin
        start_new = 1'b1;
      end
    end
    any_bad = (flush_cnt != 3'd0 && !valid_a) || (has_cur && !valid_b);

    run.count   = flush_cnt + {2'b00, has_cur};
    run.count_a = flush_cnt;
    run.valid_a = valid_a;
    run.valid_b = valid_b;
    run.eos     = end_of_string;
    run.str_ok  = !(seen_inv_r || any_bad);
    run_push    = step_en && (run.count != 3'd0);
  end

  always_comb begin
    pc_nxt       = pc_r;
    el_nxt       = el_r;
    acc_nxt      = acc_r;
    seen_inv_nxt = seen_inv_r;
    if (step_en) begin
      seen_inv_nxt = seen_inv_r || any_bad;
      if (end_of_string) begin
        pc_nxt       = 3'd0;
        el_nxt       = 3'd0;
        acc_nxt      = 32'd0;
        seen_inv_nxt = 1'b0;
      end else if (extend) begin
        pc_nxt  = pc_inc[2:0];
        acc_nxt = acc_ext;
      end else if (start_new) begin
        pc_nxt  = 3'd1;
        el_nxt  = new_len;
        acc_nxt = {24'd0, lead_payload(data_byte, new_len)};
      end else begin
        pc_nxt  = 3'd0;
        el_nxt  = 3'd0;
        acc_nxt = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= 3'd0;
      el_r       <= 3'd0;
      acc_r      <= 32'd0;
      seen_inv_r <= 1'b0;
    end else begin
      pc_r       <= pc_nxt;
      el_r       <= el_nxt;
      acc_r      <= acc_nxt;
      seen_inv_r <= seen_inv_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/utf8_validate_replace_stream.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                              Handshake
// in_ch     in   data_byte[7:0], end_of_string                        valid/ready
// out_ch    out  out_byte[7:0], byte_valid, run_last, string_last,    valid/ready
//                string_valid
// cfg_*     in   cfg_index[1:0], cfg_data[7:0]                        cfg_we
//
// One input word is accepted per cycle while the byte queue has room. Every
// input byte is written into the byte queue at once and leaves exactly once,
// in order, one word per cycle while out_ch is ready, as soon as the run that
// releases it is known. A run is decided in the same cycle the word is
// accepted, so the first result can leave on the next cycle; held bytes of
// an open sequence wait in the queue until the sequence completes or breaks,
// which is what sets the latency.
// Reset is synchronous and active low; it empties both queues and closes any
// open sequence. A stalled output only stops input once the byte queue fills.
module utf8_validate_replace_stream #(
  parameter int FIFO_DEPTH = u8vrs_pkg::DEFAULT_FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  u8vrs_in_if.sink        in_ch,
  u8vrs_out_if.source     out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import u8vrs_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // Configuration registers.
  logic       disallow_nc_r;
  logic [7:0] repl_byte_r;
  logic       repl_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disallow_nc_r <= 1'b0;
      repl_byte_r   <= REPL_BYTE_RESET;
      repl_en_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISALLOW_NC: disallow_nc_r <= cfg_data[0];
        CFG_REPL_BYTE:   repl_byte_r   <= cfg_data;
        CFG_REPL_EN:     repl_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic in_acc, out_acc, run_pop, run_push;
  run_t run_new, run_head;

  // Byte queue: every accepted byte, held or released, in arrival order.
  logic [7:0]       bytes_r [FIFO_DEPTH];
  logic [PTR_W-1:0] bwr_r, brd_r;
  logic [CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;

  // Run queue: one entry per input word that released results.
  run_t             runs_r [FIFO_DEPTH];
  logic [PTR_W-1:0] rwr_r, rrd_r;
  logic [CNT_W-1:0] run_cnt_r, run_cnt_nxt;

  // Position of the next word inside the head run.
  logic [2:0] idx_r, idx_nxt;

  logic head_last, head_bv;

  assign in_ch.ready = (byte_cnt_r != CNT_FULL);
  assign in_acc      = in_ch.valid && in_ch.ready;

  u8vrs_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_acc),
    .data_byte     (in_ch.data_byte),
    .end_of_string (in_ch.end_of_string),
    .disallow_nc   (disallow_nc_r),
    .run_push      (run_push),
    .run           (run_new)
  );

  always_comb begin
    run_head  = runs_r[rrd_r];
    head_last = (idx_r == run_head.count - 3'd1);
    head_bv   = (idx_r < run_head.count_a) ? run_head.valid_a : run_head.valid_b;
  end

  assign out_ch.valid        = (run_cnt_r != '0);
  assign out_ch.byte_valid   = head_bv;
  assign out_ch.out_byte     = (head_bv || !repl_en_r) ? bytes_r[brd_r] : repl_byte_r;
  assign out_ch.run_last     = head_last;
  assign out_ch.string_last  = head_last && run_head.eos;
  assign out_ch.string_valid = head_last && run_head.eos && run_head.str_ok;

  assign out_acc = out_ch.valid && out_ch.ready;
  assign run_pop = out_acc && head_last;

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    case ({in_acc, out_acc})
      2'b10:   byte_cnt_nxt = byte_cnt_r + CNT_W'(1);
      2'b01:   byte_cnt_nxt = byte_cnt_r - CNT_W'(1);
      default: byte_cnt_nxt = byte_cnt_r;
    endcase
    run_cnt_nxt = run_cnt_r;
    case ({run_push, run_pop})
      2'b10:   run_cnt_nxt = run_cnt_r + CNT_W'(1);
      2'b01:   run_cnt_nxt = run_cnt_r - CNT_W'(1);
      default: run_cnt_nxt = run_cnt_r;
    endcase
    idx_nxt = idx_r;
    if (out_acc) begin
      idx_nxt = head_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bytes_r[bwr_r] <= in_ch.data_byte;
    end
    if (run_push) begin
      runs_r[rwr_r] <= run_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bwr_r      <= '0;
      brd_r      <= '0;
      byte_cnt_r <= '0;
      rwr_r      <= '0;
      rrd_r      <= '0;
      run_cnt_r  <= '0;
      idx_r      <= 3'd0;
    end else begin
      if (in_acc)   bwr_r <= ptr_adv(bwr_r);
      if (out_acc)  brd_r <= ptr_adv(brd_r);
      if (run_push) rwr_r <= ptr_adv(rwr_r);
      if (run_pop)  rrd_r <= ptr_adv(rrd_r);
      byte_cnt_r <= byte_cnt_nxt;
      run_cnt_r  <= run_cnt_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // Every queued run covers at least one queued byte.
  a_runs_have_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r <= byte_cnt_r)
    else $error("run queue holds more runs than the byte queue holds bytes");

  // The word index never walks past the end of the head run.
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (idx_r < run_head.count))
    else $error("word index beyond head run length");

  // A run that is only partly delivered stays at the head.
  a_run_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !head_last) |=> (out_ch.valid && idx_r == $past(idx_r) + 3'd1))
    else $error("partly delivered run lost from the head");

  // Results are not released ahead of the bytes they describe.
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (byte_cnt_r != '0))
    else $error("result offered with empty byte queue");

endmodule

`default_nettype wire
